@@ src/rcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsc_pkg
// Shared types and constants for the reference-counted slot cache.
// ----------------------------------------------------------------------------
package rcsc_pkg;

   localparam int KEY_W    = 31;
   localparam int CNT_W    = 16;
   localparam int SLOT_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_HIT   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOC = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_HELD  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FREED = 3'd4;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } cmd_type;

endpackage

@@ src/rcsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcsc_ctrl
// Sequencer: capture a request, run the tag compare, then write back.
// ----------------------------------------------------------------------------
module rcsc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output rcsc_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy        = (state_ff == S_LOOKUP);
   assign cmd.capture = start && !busy;
   assign cmd.lookup  = (state_ff == S_LOOKUP);
   assign cmd.update  = (state_ff == S_UPDATE);

   always_comb begin
      unique case (state_ff) inside
         S_IDLE, S_UPDATE: state_in = start ? S_LOOKUP : S_IDLE;
         S_LOOKUP:         state_in = S_UPDATE;
         default:          state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/rcsc_dp.sv @@
// ----------------------------------------------------------------------------
// rcsc_dp
// Slot table, parallel key compare, allocation and release logic, response.
// ----------------------------------------------------------------------------
module rcsc_dp #(
   parameter int ENTRIES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rcsc_pkg::cmd_type               cmd,
   input  logic                            req_operation,
   input  logic [rcsc_pkg::KEY_W-1:0]      req_key,
   input  logic [rcsc_pkg::SLOT_W-1:0]     req_slot,
   output logic                            rsp_valid,
   output logic [rcsc_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [rcsc_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic                              op_ff;
   logic [rcsc_pkg::KEY_W-1:0]        key_ff;
   logic [rcsc_pkg::SLOT_W-1:0]       slot_ff;

   logic [ENTRIES-1:0]                valid_ff;
   logic [ENTRIES-1:0]                valid_in;
   logic [rcsc_pkg::KEY_W-1:0]        key_tab_ff [ENTRIES];
   logic [rcsc_pkg::KEY_W-1:0]        key_tab_in [ENTRIES];
   logic [rcsc_pkg::CNT_W-1:0]        cnt_ff [ENTRIES];
   logic [rcsc_pkg::CNT_W-1:0]        cnt_in [ENTRIES];

   logic [ENTRIES-1:0]                hit_vec_ff;
   logic [ENTRIES-1:0]                hit_vec_in;
   logic [ENTRIES-1:0]                hit_sel;
   logic [ENTRIES-1:0]                free_vec;
   logic [ENTRIES-1:0]                free_sel;
   logic [ENTRIES-1:0]                rel_sel;
   logic [ENTRIES-1:0]                gt1_vec;
   logic                              hit_any;
   logic                              free_any;
   logic                              held;
   logic                              acq;
   logic                              rel_in_range;
   logic [7:0]                        slot_wide;
   logic [IDX_W-1:0]                  rel_idx;
   logic [IDX_W-1:0]                  hit_idx;
   logic [IDX_W-1:0]                  free_idx;
   logic [7:0]                        idx_wide;

   logic                              rsp_valid_ff;
   logic [rcsc_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic [rcsc_pkg::SLOT_W-1:0]       rsp_slot_in;
   logic [rcsc_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [rcsc_pkg::STATUS_W-1:0]     rsp_status_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         key_ff  <= req_key;
         slot_ff <= req_slot;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec_in[i] = valid_ff[i] && (key_tab_ff[i] == key_ff);
         gt1_vec[i]    = valid_ff[i] && (cnt_ff[i] > rcsc_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_vec_ff <= hit_vec_in;
      end
   end

   assign acq          = (op_ff == rcsc_pkg::OP_ACQUIRE);
   assign free_vec     = ~valid_ff;
   assign hit_sel      = hit_vec_ff & (~hit_vec_ff + ENTRIES'(1));
   assign free_sel     = free_vec & (~free_vec + ENTRIES'(1));
   assign hit_any      = |hit_vec_ff;
   assign free_any     = |free_vec;
   assign slot_wide    = 8'(slot_ff);
   assign rel_idx      = slot_wide[IDX_W-1:0];
   assign rel_in_range = (slot_wide < 8'(ENTRIES));
   assign rel_sel      = rel_in_range ? (ENTRIES'(1) << rel_idx) : '0;
   assign held         = |(rel_sel & gt1_vec);

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_idx  = hit_idx  | (hit_sel[i]  ? IDX_W'(i) : '0);
         free_idx = free_idx | (free_sel[i] ? IDX_W'(i) : '0);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i]   = valid_ff[i];
         key_tab_in[i] = key_tab_ff[i];
         cnt_in[i]     = cnt_ff[i];
         if (acq) begin
            if (hit_any) begin
               if (hit_sel[i] && (cnt_ff[i] != rcsc_pkg::COUNT_MAX)) begin
                  cnt_in[i] = cnt_ff[i] + rcsc_pkg::CNT_W'(1);
               end
            end else if (free_sel[i]) begin
               valid_in[i]   = 1'b1;
               key_tab_in[i] = key_ff;
               cnt_in[i]     = rcsc_pkg::CNT_W'(1);
            end
         end else if (rel_sel[i]) begin
            if (gt1_vec[i]) begin
               cnt_in[i] = cnt_ff[i] - rcsc_pkg::CNT_W'(1);
            end else begin
               valid_in[i]   = 1'b0;
               key_tab_in[i] = '0;
               cnt_in[i]     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.update) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            key_tab_ff[i] <= key_tab_in[i];
            cnt_ff[i]     <= cnt_in[i];
         end
      end
   end

   always_comb begin
      idx_wide      = 8'(hit_idx);
      rsp_slot_in   = slot_ff;
      rsp_status_in = held ? rcsc_pkg::STATUS_HELD : rcsc_pkg::STATUS_FREED;
      if (acq) begin
         if (hit_any) begin
            idx_wide      = 8'(hit_idx);
            rsp_status_in = rcsc_pkg::STATUS_HIT;
         end else if (free_any) begin
            idx_wide      = 8'(free_idx);
            rsp_status_in = rcsc_pkg::STATUS_ALLOC;
         end else begin
            idx_wide      = '0;
            rsp_status_in = rcsc_pkg::STATUS_FULL;
         end
         rsp_slot_in = idx_wide[rcsc_pkg::SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.update))
      else $error("response without a preceding update");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $onehot0(hit_vec_ff))
      else $error("key present in more than one valid slot");

   a_alloc_claims: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && acq && !hit_any && free_any)
      |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("allocation did not claim exactly one slot");
`endif

endmodule

@@ src/refcounted_slot_cache.sv @@
// ----------------------------------------------------------------------------
// refcounted_slot_cache
// Reference-counted slot table with acquire-by-key and release-by-slot.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. The key
// compare across all slots is registered in the cycle after the transfer,
// and the table write-back happens in the next cycle; rsp_valid is registered
// with the write-back and pulses for one cycle. busy is high only during
// the compare cycle: a new request can be taken before the last is through,
// including in the cycle the table is written. The receiver cannot stall;
// each result is valid for that single rsp_valid cycle only.
module refcounted_slot_cache #(
   parameter int ENTRIES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [rcsc_pkg::KEY_W-1:0]      req_key,
   input  logic [rcsc_pkg::SLOT_W-1:0]     req_slot,
   output logic                            rsp_valid,
   output logic [rcsc_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [rcsc_pkg::STATUS_W-1:0]   rsp_status
);

   rcsc_pkg::cmd_type cmd;

   rcsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rcsc_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

endmodule
